// ===== hdl/cnf_assignment_trail_evaluator_core_assert.svh =====
// Assertion macros shared by the CNF trail evaluator RTL.
// Needs nothing but a clock, an active-low reset and boolean expressions.
`ifndef CNF_ASSIGNMENT_TRAIL_EVALUATOR_CORE_ASSERT_SVH
`define CNF_ASSIGNMENT_TRAIL_EVALUATOR_CORE_ASSERT_SVH

// Same-cycle implication: whenever a holds, c holds too.
`define CATE_ASSERT_IMPL(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Next-cycle implication: whenever a holds, c holds in the next cycle.
`define CATE_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// ===== hdl/cate_pkg.sv =====
// Shared types and constants for the CNF assignment trail evaluator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package cate_pkg;

	localparam int unsigned MAX_VARS_DEF     = 256;
	localparam int unsigned MAX_LITERALS_DEF = 1024;

	// fixed field widths
	localparam int unsigned VAR_W  = 9;
	localparam int unsigned LIT_W  = 10;
	localparam int unsigned CFG_W  = 9;
	localparam int unsigned APB_AW = 3;
	localparam int unsigned APB_DW = 32;

	localparam logic [CFG_W-1:0] VAR_COUNT_RESET = 9'd256;

	// register index, taken from paddr[2]
	localparam logic REG_VARIABLE_COUNT = 1'b0;

	typedef enum logic [1:0] {
		REQ_APPEND    = 2'd0,
		REQ_ASSIGN    = 2'd1,
		REQ_BACKTRACK = 2'd2,
		REQ_EVALUATE  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_CONFLICT     = 3'd1,
		ST_FULL         = 3'd2,
		ST_NOT_ON_TRAIL = 3'd3,
		ST_RANGE        = 3'd4
	} status_t;

	// commands into the assignment unit
	typedef struct packed {
		logic lookup;   // read the entry of the given variable
		logic push;     // assign the variable and push it on the trail
		logic cut;      // drop the trail back to the given position
		logic value;    // value for push
	} asgn_cmd_t;

	// lookup answer and status of the assignment unit
	typedef struct packed {
		logic valid;     // lookup answer present this cycle
		logic assigned;  // variable currently assigned
		logic value;     // its value when assigned
		logic busy;      // lookups still in flight
		logic clearing;  // post-reset clearing pass running
	} asgn_res_t;

endpackage

`default_nettype wire

// ===== hdl/cnf_assignment_trail_evaluator_core.sv =====
// Top level of the CNF assignment trail evaluator: request sequencer, config
// register, output register. Depends on cate_pkg, cate_store, cate_asgn and
// cnf_assignment_trail_evaluator_core_assert.svh.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+------------------------------
//  request   | in        | s_tvalid / s_tready        | s_tdata, s_tuser, s_tlast
//  result    | out       | m_tvalid / m_tready        | m_tdata
//  config    | in        | psel & penable & pwrite    | paddr, pwdata (prdata on read)
//
// One request is in work at a time. Append goes from acceptance straight to the
// result state. Assign / backtrack wait on the two chained memory reads (table
// entry, then trail slot), unless the variable is out of range. Evaluate reads one
// stored literal per cycle through a three-read pipeline (store, table, trail),
// then drains that pipeline. A result that m_tready holds back delays the next
// request. After reset a clearing pass sweeps all MAX_VARS + 1 table entries;
// s_tready stays low meanwhile, config writes are taken as ever.
`timescale 1ns / 1ps
`default_nettype none
`include "cnf_assignment_trail_evaluator_core_assert.svh"

module cnf_assignment_trail_evaluator_core import cate_pkg::*; #(
	parameter int unsigned MAX_VARS     = MAX_VARS_DEF,
	parameter int unsigned MAX_LITERALS = MAX_LITERALS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// request stream
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [23:0]       s_tdata,   // [9:0] literal, [18:10] var_index,
	                                          // [19] assign_value, [23:20] zero
	input  wire logic [1:0]        s_tuser,   // [1:0] req_type
	input  wire logic              s_tlast,   // clause_end
	// result stream
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [15:0]       m_tdata,   // [2:0] status, [3] formula_true,
	                                          // [12:4] trail_depth, [15:13] zero
	// config port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	localparam int unsigned AW   = $clog2(MAX_VARS + 1);
	localparam int unsigned LAW  = $clog2(MAX_LITERALS);
	localparam int unsigned LCW  = $clog2(MAX_LITERALS + 1);
	localparam int unsigned VCAP = (MAX_VARS > 511) ? 511 : MAX_VARS;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_EVAL,
		S_RESULT
	} state_t;

	state_t            state_q;
	req_t              req_q;
	logic              val_q;
	logic [AW-1:0]     var_q;
	status_t           status_q;
	logic              ftrue_q;
	logic              m_tvalid_q;
	logic [15:0]       m_tdata_q;
	logic [CFG_W-1:0]  vc_q;

	// evaluate walk
	logic [LCW-1:0]    k_q;
	logic              rdv_q;
	logic [1:0]        meta_b_q, meta_c_q;   // {neg, end}
	logic              sat_q, open_q, fail_q;

	// request decode
	logic              s_acc;
	req_t              in_req;
	logic [LIT_W-1:0]  in_lit;
	logic [VAR_W-1:0]  in_var;
	logic              in_val;
	logic              lit_neg;
	logic [LIT_W-1:0]  lit_mag;
	logic [VAR_W-1:0]  limit;
	logic              lit_bad, var_bad;

	// store and assignment unit hookup
	logic              st_wr_en, st_rd_en;
	logic [AW-1:0]     st_rd_var;
	logic              st_rd_neg, st_rd_end;
	logic [LCW-1:0]    st_count;
	logic              st_full;
	asgn_cmd_t         acmd;
	asgn_res_t         ares;
	logic [AW-1:0]     a_var;
	logic [AW-1:0]     a_pos;
	logic [AW-1:0]     trail_count;
	logic              tc_full;
	logic              lit_true;
	logic              eval_done;
	logic              cfg_wr;

	assign s_acc   = s_tvalid && s_tready;
	assign in_req  = req_t'(s_tuser);
	assign in_lit  = s_tdata[9:0];
	assign in_var  = s_tdata[18:10];
	assign in_val  = s_tdata[19];

	// valid variables are 1 .. min(variable_count, MAX_VARS)
	assign limit   = (vc_q < VAR_W'(VCAP)) ? vc_q : VAR_W'(VCAP);
	assign lit_neg = in_lit[LIT_W-1];
	assign lit_mag = lit_neg ? (~in_lit + LIT_W'(1)) : in_lit;
	assign lit_bad = (lit_mag == '0) || (lit_mag > {1'b0, limit});
	assign var_bad = (in_var == '0) || (in_var > limit);

	assign st_full = st_count >= LCW'(MAX_LITERALS);
	assign tc_full = trail_count >= AW'(MAX_VARS);

	// hold off requests while busy or while the table is being cleared
	assign s_tready = (state_q == S_IDLE) && !ares.clearing;

	// append writes the store in the accept cycle
	assign st_wr_en = s_acc && (in_req == REQ_APPEND) && !lit_bad && !st_full;
	assign st_rd_en = (state_q == S_EVAL) && (k_q != st_count);

	cate_store #(
		.MAX_LITERALS (MAX_LITERALS),
		.VW           (AW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (st_wr_en),
		.wr_var  (AW'(lit_mag)),
		.wr_neg  (lit_neg),
		.wr_end  (s_tlast),
		.rd_en   (st_rd_en),
		.rd_addr (k_q[LAW-1:0]),
		.rd_var  (st_rd_var),
		.rd_neg  (st_rd_neg),
		.rd_end  (st_rd_end),
		.count   (st_count)
	);

	// lookup source: the request itself, the walked literal, or the held variable
	always_comb begin
		acmd  = '0;
		a_var = var_q;
		case (state_q)
			S_IDLE: begin
				a_var       = AW'(in_var);
				acmd.lookup = s_acc && !var_bad &&
				              ((in_req == REQ_ASSIGN) || (in_req == REQ_BACKTRACK));
			end
			S_EVAL: begin
				a_var       = st_rd_var;
				acmd.lookup = rdv_q;
			end
			S_LOOK: begin
				acmd.push  = ares.valid && (req_q == REQ_ASSIGN) && !ares.assigned &&
				             !tc_full;
				acmd.cut   = ares.valid && (req_q == REQ_BACKTRACK) && ares.assigned;
				acmd.value = val_q;
			end
			default: ;
		endcase
	end

	cate_asgn #(
		.MAX_VARS (MAX_VARS)
	) u_asgn (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (acmd),
		.var_in      (a_var),
		.cut_pos     (a_pos),
		.res         (ares),
		.res_pos     (a_pos),
		.trail_count (trail_count)
	);

	// literal truth; an unassigned variable makes no literal true
	assign lit_true  = ares.assigned && (meta_c_q[1] ? !ares.value : ares.value);
	assign eval_done = (k_q == st_count) && !rdv_q && !ares.busy;

	// evaluate pipeline: advance the walk pointer, align literal marks, fold clauses
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= '0;
			rdv_q    <= 1'b0;
			meta_b_q <= '0;
			meta_c_q <= '0;
			sat_q    <= 1'b0;
			open_q   <= 1'b0;
			fail_q   <= 1'b0;
		end else begin
			rdv_q    <= st_rd_en;
			meta_c_q <= meta_b_q;
			if (rdv_q)
				meta_b_q <= {st_rd_neg, st_rd_end};
			if (s_acc && (in_req == REQ_EVALUATE)) begin
				k_q    <= '0;
				sat_q  <= 1'b0;
				open_q <= 1'b0;
				fail_q <= 1'b0;
			end else begin
				if (st_rd_en)
					k_q <= k_q + LCW'(1);
				if ((state_q == S_EVAL) && ares.valid) begin
					// a closing literal settles its clause, others extend it
					if (meta_c_q[0]) begin
						if (!(sat_q || lit_true))
							fail_q <= 1'b1;
						sat_q  <= 1'b0;
						open_q <= 1'b0;
					end else begin
						sat_q  <= sat_q || lit_true;
						open_q <= 1'b1;
					end
				end
			end
		end
	end

	// request sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			req_q      <= REQ_APPEND;
			val_q      <= 1'b0;
			var_q      <= '0;
			status_q   <= ST_OK;
			ftrue_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			// drop a taken result unless a new one is loaded below
			if (m_tready && (state_q != S_RESULT))
				m_tvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						req_q   <= in_req;
						val_q   <= in_val;
						var_q   <= AW'(in_var);
						ftrue_q <= 1'b0;
						case (in_req)
							REQ_APPEND: begin
								status_q <= lit_bad ? ST_RANGE : (st_full ? ST_FULL : ST_OK);
								state_q  <= S_RESULT;
							end
							REQ_ASSIGN, REQ_BACKTRACK: begin
								if (var_bad) begin
									status_q <= ST_RANGE;
									state_q  <= S_RESULT;
								end else begin
									state_q <= S_LOOK;
								end
							end
							default: begin
								state_q <= S_EVAL;
							end
						endcase
					end
				end
				S_LOOK: begin
					if (ares.valid) begin
						if (req_q == REQ_ASSIGN) begin
							if (ares.assigned)
								status_q <= (ares.value == val_q) ? ST_OK : ST_CONFLICT;
							else
								status_q <= tc_full ? ST_FULL : ST_OK;
						end else begin
							status_q <= ares.assigned ? ST_OK : ST_NOT_ON_TRAIL;
						end
						state_q <= S_RESULT;
					end
				end
				S_EVAL: begin
					if (eval_done) begin
						// an open last clause counts like a closed one
						ftrue_q  <= !fail_q && !(open_q && !sat_q);
						status_q <= ST_OK;
						state_q  <= S_RESULT;
					end
				end
				S_RESULT: begin
					// trail count already reflects this request here
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {3'b000, VAR_W'(trail_count), ftrue_q, status_q};
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// config register; the index comes from paddr[2]
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_VARIABLE_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vc_q <= VAR_COUNT_RESET;
		else if (cfg_wr)
			vc_q <= pwdata[CFG_W-1:0];
	end

	assign prdata = (paddr[2] == REG_VARIABLE_COUNT) ? APB_DW'(vc_q) : '0;
	assign pready = 1'b1;

	`CATE_ASSERT_NEXT(a_one_request, clk, arst_n, s_tvalid && s_tready, !s_tready, "request accepted while another is in work")
	`CATE_ASSERT_IMPL(a_push_unassigned, clk, arst_n, acmd.push, ares.valid && !ares.assigned && (req_q == REQ_ASSIGN), "push without an unassigned lookup")
	`CATE_ASSERT_IMPL(a_trail_bound, clk, arst_n, 1'b1, trail_count <= AW'(MAX_VARS), "trail count past capacity")
	`CATE_ASSERT_IMPL(a_store_bound, clk, arst_n, 1'b1, st_count <= LCW'(MAX_LITERALS), "literal count past capacity")

endmodule

`default_nettype wire

// ===== hdl/cate_store.sv =====
// Clause store: literal memory with append pointer and registered read port.
// Depends on cate_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cate_store import cate_pkg::*; #(
	parameter int unsigned MAX_LITERALS = MAX_LITERALS_DEF,
	parameter int unsigned VW = VAR_W,
	localparam int unsigned LAW = $clog2(MAX_LITERALS),
	localparam int unsigned LCW = $clog2(MAX_LITERALS + 1)
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  wire logic [VW-1:0]  wr_var,
	input  wire logic           wr_neg,
	input  wire logic           wr_end,
	input  wire logic           rd_en,
	input  wire logic [LAW-1:0] rd_addr,
	output logic      [VW-1:0]  rd_var,
	output logic                rd_neg,
	output logic                rd_end,
	output logic      [LCW-1:0] count
);

	logic [VW+1:0]  mem [MAX_LITERALS];
	logic [VW+1:0]  rd_q;
	logic [LCW-1:0] count_q;

	// append at the fill pointer; caller guarantees the store is not full
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[count_q[LAW-1:0]] <= {wr_var, wr_neg, wr_end};
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else if (wr_en)
			count_q <= count_q + LCW'(1);
	end

	assign rd_var = rd_q[VW+1:2];
	assign rd_neg = rd_q[1];
	assign rd_end = rd_q[0];
	assign count  = count_q;

endmodule

`default_nettype wire

// ===== hdl/cate_asgn.sv =====
// Assignment unit: per-variable table {value, trail position} and trail memory.
// A variable is assigned when its position lies below the trail count and the
// trail holds it there. Depends on cate_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cate_asgn import cate_pkg::*; #(
	parameter int unsigned MAX_VARS = MAX_VARS_DEF,
	localparam int unsigned AW  = $clog2(MAX_VARS + 1),
	localparam int unsigned TIW = $clog2(MAX_VARS)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire asgn_cmd_t     cmd,
	input  wire logic [AW-1:0] var_in,
	input  wire logic [AW-1:0] cut_pos,
	output asgn_res_t          res,
	output logic      [AW-1:0] res_pos,
	output logic      [AW-1:0] trail_count
);

	logic [AW:0]   vt    [MAX_VARS + 1];
	logic [AW-1:0] trail [MAX_VARS];

	logic          clr_q;
	logic [AW-1:0] clr_cnt_q;
	logic [AW-1:0] tc_q;

	logic          v_s1, v_s2;
	logic [AW:0]   vt_s1;
	logic [AW-1:0] var_s1, var_s2;
	logic [AW-1:0] pos_s2;
	logic          val_s2;
	logic [AW-1:0] tr_s2;

	logic          vt_we;
	logic [AW-1:0] vt_wa;
	logic [AW:0]   vt_wd;
	logic [AW-1:0] pos_s1;

	// clearing pass parks every entry at a position no trail count reaches
	assign vt_we  = clr_q || cmd.push;
	assign vt_wa  = clr_q ? clr_cnt_q : var_in;
	assign vt_wd  = clr_q ? {1'b0, AW'(MAX_VARS)} : {cmd.value, tc_q};
	assign pos_s1 = vt_s1[AW-1:0];

	always_ff @(posedge clk) begin
		if (vt_we)
			vt[vt_wa] <= vt_wd;
		if (cmd.lookup) begin
			vt_s1  <= vt[var_in];
			var_s1 <= var_in;
		end
		if (cmd.push)
			trail[tc_q[TIW-1:0]] <= var_in;
		if (v_s1) begin
			tr_s2  <= trail[pos_s1[TIW-1:0]];
			pos_s2 <= pos_s1;
			val_s2 <= vt_s1[AW];
			var_s2 <= var_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
			tc_q      <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
		end else begin
			v_s1 <= cmd.lookup;
			v_s2 <= v_s1;
			if (clr_q) begin
				if (clr_cnt_q == AW'(MAX_VARS))
					clr_q <= 1'b0;
				else
					clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (cmd.push)
				tc_q <= tc_q + AW'(1);
			else if (cmd.cut)
				tc_q <= cut_pos;
		end
	end

	always_comb begin
		res          = '0;
		res.valid    = v_s2;
		res.assigned = v_s2 && (pos_s2 < tc_q) && (tr_s2 == var_s2);
		res.value    = val_s2;
		res.busy     = v_s1 || v_s2;
		res.clearing = clr_q;
	end

	assign res_pos     = pos_s2;
	assign trail_count = tc_q;

endmodule

`default_nettype wire

// ===== tb/sv/cate_trail_checker.sv =====
// Checker for the CNF assignment trail evaluator: watches the request, result and
// config channels, predicts every result and compares it field by field.
// Depends on cate_pkg for the request and status codes and the field widths.
`timescale 1ns / 1ps

module cate_trail_checker import cate_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	input  wire logic              s_tready,
	input  wire logic [23:0]       s_tdata,   // [9:0] literal, [18:10] var_index,
	                                          // [19] assign_value, [23:20] zero
	input  wire logic [1:0]        s_tuser,   // [1:0] req_type
	input  wire logic              s_tlast,
	input  wire logic              m_tvalid,
	input  wire logic              m_tready,
	input  wire logic [15:0]       m_tdata,   // [2:0] status, [3] formula_true,
	                                          // [12:4] trail_depth, [15:13] zero
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	input  wire logic [APB_DW-1:0] prdata,
	input  wire logic              pready,
	output int                     fail_count,
	output int                     pending,
	output int                     result_count,
	output int                     sat_count
);

	localparam int unsigned VARS = MAX_VARS_DEF;
	localparam int unsigned LITS = MAX_LITERALS_DEF;

	typedef enum logic [1:0] {
		VAR_FREE = 2'd0,
		VAR_LOW  = 2'd1,
		VAR_HIGH = 2'd2
	} var_value_t;

	typedef struct packed {
		status_t    status;
		logic       sat;
		logic [8:0] depth;
	} outcome_t;

	outcome_t         outcomes_q[$];
	logic [CFG_W-1:0] var_count;
	logic [8:0]       lit_var [LITS];
	logic             lit_neg [LITS];
	logic             lit_end [LITS];
	int unsigned      lit_total;
	var_value_t       var_value [VARS+1];
	logic [8:0]       trail_var [VARS];
	int unsigned      trail_len;
	outcome_t         got;
	outcome_t         want;
	status_t          st;
	logic             sat_now;

	initial begin
		fail_count   = 0;
		pending      = 0;
		result_count = 0;
		sat_count    = 0;
	end

	task automatic report_mismatch(input string what);
		if (fail_count < 50) begin
			$display("[%0t] mismatch: %s", $time, what);
		end
		fail_count++;
	endtask

	function automatic int unsigned usable_vars();
		return (var_count < VARS) ? var_count : VARS;
	endfunction

	// a clause in progress after the last end mark counts like a closed one
	function automatic logic formula_sat();
		logic clause_ok = 1'b0;
		logic open      = 1'b0;
		for (int unsigned k = 0; k < lit_total; k++) begin
			open = 1'b1;
			if (var_value[lit_var[k]] == (lit_neg[k] ? VAR_LOW : VAR_HIGH)) begin
				clause_ok = 1'b1;
			end
			if (lit_end[k]) begin
				if (!clause_ok) begin
					return 1'b0;
				end
				clause_ok = 1'b0;
				open      = 1'b0;
			end
		end
		return !(open && !clause_ok);
	endfunction

	// range is checked before fullness
	function automatic status_t store_literal(input logic [9:0] raw, input logic close);
		int unsigned mag;
		mag = raw[9] ? 1024 - raw : raw;
		if (mag == 0 || mag > usable_vars()) begin
			return ST_RANGE;
		end
		if (lit_total >= LITS) begin
			return ST_FULL;
		end
		lit_var[lit_total] = 9'(mag);
		lit_neg[lit_total] = raw[9];
		lit_end[lit_total] = close;
		lit_total++;
		return ST_OK;
	endfunction

	function automatic status_t set_variable(input logic [8:0] idx, input logic val);
		var_value_t wanted;
		wanted = val ? VAR_HIGH : VAR_LOW;
		if (idx == 0 || idx > usable_vars()) begin
			return ST_RANGE;
		end
		if (var_value[idx] != VAR_FREE) begin
			if (var_value[idx] == wanted) begin
				return ST_OK;
			end
			return ST_CONFLICT;
		end
		if (trail_len >= VARS) begin
			return ST_FULL;
		end
		var_value[idx]       = wanted;
		trail_var[trail_len] = idx;
		trail_len++;
		return ST_OK;
	endfunction

	function automatic status_t undo_from(input logic [8:0] idx);
		int unsigned pos;
		if (idx == 0 || idx > usable_vars()) begin
			return ST_RANGE;
		end
		pos = 0;
		while (pos < trail_len && trail_var[pos] != idx) begin
			pos++;
		end
		if (pos >= trail_len) begin
			return ST_NOT_ON_TRAIL;
		end
		for (int unsigned j = pos; j < trail_len; j++) begin
			var_value[trail_var[j]] = VAR_FREE;
		end
		trail_len = pos;
		return ST_OK;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_count = VAR_COUNT_RESET;
			lit_total = 0;
			trail_len = 0;
			for (int unsigned i = 0; i <= VARS; i++) begin
				var_value[i] = VAR_FREE;
			end
			outcomes_q.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == REG_VARIABLE_COUNT) begin
						var_count = pwdata[CFG_W-1:0];
					end
				end else if (paddr[2] == REG_VARIABLE_COUNT &&
						prdata !== APB_DW'(var_count)) begin
					report_mismatch($sformatf("variable_count read %0d, expected %0d",
						prdata, var_count));
				end
			end

			// retire the oldest expectation before queuing a new one
			if (m_tvalid && m_tready) begin
				got = '{status: status_t'(m_tdata[2:0]), sat: m_tdata[3],
					depth: m_tdata[12:4]};
				result_count++;
				if (outcomes_q.size() == 0) begin
					report_mismatch("result with no request outstanding");
				end else begin
					want = outcomes_q.pop_front();
					if (got.status !== want.status) begin
						report_mismatch($sformatf("status %0d, expected %s",
							m_tdata[2:0], want.status.name()));
					end
					if (got.sat !== want.sat) begin
						report_mismatch($sformatf("formula_true %b, expected %b",
							got.sat, want.sat));
					end
					if (got.depth !== want.depth) begin
						report_mismatch($sformatf("trail_depth %0d, expected %0d",
							got.depth, want.depth));
					end
					if (want.sat) begin
						sat_count++;
					end
				end
			end

			if (s_tvalid && s_tready) begin
				sat_now = 1'b0;
				case (req_t'(s_tuser))
					REQ_APPEND:    st = store_literal(s_tdata[9:0], s_tlast);
					REQ_ASSIGN:    st = set_variable(s_tdata[18:10], s_tdata[19]);
					REQ_BACKTRACK: st = undo_from(s_tdata[18:10]);
					default: begin
						st      = ST_OK;
						sat_now = formula_sat();
					end
				endcase
				outcomes_q.push_back('{status: st, sat: sat_now, depth: 9'(trail_len)});
			end

			pending <= outcomes_q.size();
		end
	end

endmodule

// ===== tb/sv/cnf_assignment_trail_evaluator_core_test.sv =====
// Top of the CNF assignment trail evaluator testbench: clock, reset, request and
// config stimulus, result back-pressure and the final verdict.
// Depends on cate_pkg, the block itself and cate_trail_checker.
`timescale 1ns / 1ps

module cnf_assignment_trail_evaluator_core_test import cate_pkg::*; ();

	localparam int unsigned RANDOM_REQUESTS = 220;
	localparam int unsigned PHASE_LEN       = 28;
	localparam int unsigned TAIL_REQUESTS   = 16;
	localparam int unsigned WINDOW_MAX      = 24;
	// about six hundred requests, each a full-store evaluation plus both sides'
	// longest bursts, with ample margin on top
	localparam int unsigned CYCLE_LIMIT     = 10_000_000;

	localparam logic [APB_AW-1:0] ADDR_VARIABLE_COUNT = {REG_VARIABLE_COUNT, 2'b00};
	localparam logic [APB_AW-1:0] ADDR_SPARE          = 3'b100;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [23:0]       s_tdata  = '0;
	logic [1:0]        s_tuser  = '0;
	logic              s_tlast  = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [15:0]       m_tdata;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [APB_AW-1:0] paddr    = '0;
	logic [APB_DW-1:0] pwdata   = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	int          fail_count;
	int          pending;
	int          result_count;
	int          sat_count;
	int unsigned cycle_count   = 0;
	int unsigned request_count = 0;
	int unsigned setting_count = 0;
	int unsigned gap_pct       = 30;
	int unsigned stall_pct     = 30;
	logic        calm          = 1'b0;
	int unsigned var_cfg       = VAR_COUNT_RESET;
	int unsigned count_plan [8] = '{256, 16, 1, 24, 511, 200, 2, 256};
	// hidden satisfying assignment that well-formed clauses are built around
	logic        sol [1:256];

	cnf_assignment_trail_evaluator_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	cate_trail_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.fail_count   (fail_count),
		.pending      (pending),
		.result_count (result_count),
		.sat_count    (sat_count)
	);

	always #2 clk = ~clk;

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("cnf_assignment_trail_evaluator_core_test failed");
			$finish;
		end
	end

	// Result back-pressure: hold m_tready in bursts of random length, ready or
	// stalled by stall_pct; drop all stalls once the calm tail of the run starts.
	initial begin : result_backpressure
		int unsigned hold = 0;
		forever begin
			@(posedge clk);
			if (calm) begin
				m_tready <= 1'b1;
				hold = 0;
			end else if (hold == 0) begin
				hold = $urandom_range(1, 16);
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
			end else begin
				hold--;
			end
		end
	end

	// Number of low variables that well-formed clauses draw from, kept small so
	// that a full solve of the window stays cheap.
	function automatic int unsigned window();
		int unsigned lim;
		lim = (var_cfg > MAX_VARS_DEF) ? MAX_VARS_DEF : var_cfg;
		if (lim == 0) begin
			return 1;
		end
		return (lim > WINDOW_MAX) ? WINDOW_MAX : lim;
	endfunction

	// Present one request and hold it until accepted. An optional idle burst comes
	// first; s_tvalid stays high across back-to-back requests.
	task automatic send_request(input req_t kind, input logic [9:0] lit, input logic close,
			input logic [8:0] vidx, input logic val);
		int unsigned gap;
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 16);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= {4'b0, val, vidx, lit};
		s_tuser  <= kind;
		s_tlast  <= close;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		request_count++;
	endtask

	// Fields a request type ignores still get random content.
	task automatic append_literal(input int lit, input logic close);
		send_request(REQ_APPEND, 10'(lit), close, 9'($urandom_range(0, 511)),
			1'($urandom_range(0, 1)));
	endtask

	task automatic assign_variable(input int unsigned v, input logic val);
		send_request(REQ_ASSIGN, 10'($urandom), 1'($urandom), 9'(v), val);
	endtask

	task automatic backtrack_to(input int unsigned v);
		send_request(REQ_BACKTRACK, 10'($urandom), 1'($urandom), 9'(v), 1'($urandom));
	endtask

	task automatic evaluate_formula();
		send_request(REQ_EVALUATE, 10'($urandom), 1'($urandom), 9'($urandom), 1'($urandom));
	endtask

	// Noise: any request type with any field content. Appended noise never closes
	// a clause, so it merges into the next well-formed one instead of poisoning
	// the formula for good.
	task automatic noise_request();
		req_t kind;
		kind = req_t'($urandom_range(0, 3));
		send_request(kind, 10'($urandom), (kind == REQ_APPEND) ? 1'b0 : 1'($urandom),
			9'($urandom), 1'($urandom));
	endtask

	// One clause of 1 to 4 window literals, one of them agreeing with sol.
	task automatic build_clause();
		int unsigned len;
		int unsigned keep;
		int unsigned v;
		logic        pol;
		len  = $urandom_range(1, 4);
		keep = $urandom_range(0, len - 1);
		for (int unsigned i = 0; i < len; i++) begin
			v   = $urandom_range(1, window());
			pol = (i == keep) ? sol[v] : 1'($urandom_range(0, 1));
			append_literal(pol ? int'(v) : -int'(v), i == len - 1);
		end
	endtask

	// Clear the window off the trail, assign it from sol, then evaluate. Variable
	// 256 is set too: the tautology built up front needs it assigned either way.
	task automatic solve_window();
		for (int unsigned v = 1; v <= window(); v++) begin
			backtrack_to(v);
		end
		for (int unsigned v = 1; v <= window(); v++) begin
			assign_variable(v, sol[v]);
		end
		if (var_cfg >= MAX_VARS_DEF) begin
			assign_variable(MAX_VARS_DEF, sol[MAX_VARS_DEF]);
		end
		evaluate_formula();
	endtask

	// APB setup then access phase, then an idle step so back-to-back accesses
	// never lower and raise psel in the same step.
	task automatic apb_access(input logic write, input logic [APB_AW-1:0] addr,
			input logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write variable_count and read it back.
	task automatic set_variable_count(input int unsigned n);
		apb_access(1'b1, ADDR_VARIABLE_COUNT, APB_DW'(n));
		var_cfg = n;
		setting_count++;
		apb_access(1'b0, ADDR_VARIABLE_COUNT, '0);
	endtask

	// Stop sending and wait until every request has its result back.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin : stimulus
		int unsigned phase;
		int unsigned phase_mark;
		int unsigned base;
		int unsigned pick;
		int unsigned v;

		foreach (sol[i]) begin
			sol[i] = 1'($urandom_range(0, 1));
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: edge fields, every request type, every special case.
		evaluate_formula();                 // empty store holds
		backtrack_to(5);                    // not on trail
		assign_variable(0, 1'b1);           // variable zero
		assign_variable(257, 1'b1);         // just past the range
		append_literal(0, 1'b1);            // literal zero
		append_literal(257, 1'b1);
		append_literal(-512, 1'b1);         // most negative literal
		append_literal(256, 1'b0);          // largest variable, open clause
		append_literal(-256, 1'b0);
		evaluate_formula();                 // open clause on an unassigned variable
		assign_variable(256, 1'b1);
		evaluate_formula();
		assign_variable(256, 1'b1);         // same value again
		assign_variable(256, 1'b0);         // different value: conflict
		append_literal(1, 1'b1);            // close the clause
		backtrack_to(0);
		backtrack_to(256);                  // back to an empty trail
		evaluate_formula();
		backtrack_to(511);                  // all ones

		// Smallest legal variable_count: only variable 1 is usable.
		drain();
		set_variable_count(1);
		append_literal(-2, 1'b1);
		assign_variable(1, 1'b0);
		backtrack_to(1);

		// Zero variable_count: nothing is usable; a write to the spare address
		// must not touch the register.
		drain();
		set_variable_count(0);
		assign_variable(1, 1'b1);
		append_literal(1, 1'b1);
		drain();
		apb_access(1'b1, ADDR_SPARE, 32'h0000_01ff);
		apb_access(1'b0, ADDR_VARIABLE_COUNT, '0);
		backtrack_to(1);

		// Trail from empty to full depth, then unwind it with one backtrack to
		// the variable at its bottom.
		drain();
		set_variable_count(MAX_VARS_DEF);
		for (int unsigned i = 1; i <= MAX_VARS_DEF; i++) begin
			assign_variable(i, sol[i]);
		end
		evaluate_formula();
		backtrack_to(1);
		evaluate_formula();

		// Random: mostly well-formed clauses, assignments built around sol,
		// evaluations and backtracks, with noise mixed in; switch variable_count
		// and the idle mix every phase.
		base       = request_count;
		phase      = 0;
		phase_mark = request_count;
		while (request_count - base < RANDOM_REQUESTS) begin
			if (request_count >= phase_mark) begin
				drain();
				set_variable_count(count_plan[phase % 8]);
				if ($urandom_range(0, 3) == 0) begin
					apb_access(1'b1, ADDR_SPARE, $urandom);
				end
				gap_pct    = $urandom_range(0, 2) * 30;
				stall_pct  = $urandom_range(0, 2) * 30;
				phase++;
				phase_mark = request_count + PHASE_LEN;
			end
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				build_clause();
			end else if (pick < 45) begin
				repeat ($urandom_range(1, 6)) begin
					v = $urandom_range(1, window());
					assign_variable(v, ($urandom_range(0, 9) == 0) ? !sol[v] : sol[v]);
				end
			end else if (pick < 60) begin
				evaluate_formula();
			end else if (pick < 67) begin
				backtrack_to($urandom_range(1, window()));
			end else if (pick < 72) begin
				solve_window();
			end else begin
				noise_request();
			end
		end

		// Calm tail: no idling on either side. A few more clauses, then a full
		// solve of the window.
		drain();
		set_variable_count(MAX_VARS_DEF);
		calm = 1'b1;
		base = request_count;
		while (request_count - base < TAIL_REQUESTS) begin
			build_clause();
		end
		append_literal(300, 1'b1);          // past the largest variable
		append_literal(-7, 1'b1);
		solve_window();
		evaluate_formula();

		// Wait out the last results, then a short quiet stretch to catch strays.
		drain();
		repeat (64) @(posedge clk);

		$display("Summary: %0d requests under %0d variable_count settings, %0d results checked.",
			request_count, setting_count, result_count);
		$display("Summary: %0d evaluations satisfied; trail run to full depth and unwound.",
			sat_count);
		if (fail_count == 0) begin
			$display("cnf_assignment_trail_evaluator_core_test passed");
		end else begin
			$display("cnf_assignment_trail_evaluator_core_test failed");
		end
		$finish;
	end

endmodule
